// File: hw/rtl/lgfs_pkg.sv
// Package for the lattice Green-function sum: widths, constants, FSM state type,
// CSR index codes and the cosine table built at elaboration.
// No dependencies.
package lgfs_pkg;

   localparam int LATTICE_SIZE = 16;   // power of two
   localparam int DIMENSIONS   = 2;

   localparam int LAT_W  = $clog2(LATTICE_SIZE);
   localparam int IDX_W  = 2 * LAT_W;
   localparam int DATA_W = 32;
   localparam int SUM_W  = DATA_W + IDX_W;
   localparam int COS_W  = 18;
   localparam int G_W    = 21;
   localparam int PROD_W = DATA_W + G_W;
   localparam int DIFF_W = PROD_W + 1;
   localparam int RND_W  = DIFF_W + 1;
   localparam int AD_W   = 25;
   localparam int SQ_W   = 2 * AD_W - 1;
   localparam int DEN_W  = 63;
   localparam int REM_W  = 48;
   localparam int DIV_W  = REM_W + 1;
   localparam int STEP_W = $clog2(DATA_W);
   localparam int MUL_W  = DATA_W + 1;

   localparam logic signed [G_W-1:0]   G_BASE      = G_W'(262144);
   localparam logic [RND_W-1:0]        ROUND_POS   = RND_W'(32768);
   localparam logic [RND_W-1:0]        ROUND_NEG   = RND_W'(32769);
   localparam logic [RND_W-17:0]       AD_LIMIT    = (RND_W-16)'(64'h100_0000);
   localparam logic [DEN_W-1:0]        SAT_LIMIT   = DEN_W'(64'h1_0000);
   localparam logic [DEN_W-1:0]        DIV_LIMIT   = DEN_W'(64'h1_0000_0000_0000);
   localparam logic [REM_W-1:0]        REM_INIT    = REM_W'(64'h1_0000);
   localparam logic [DATA_W-1:0]       QUO_MAX     = '1;
   localparam logic [IDX_W-1:0]        IDX_LAST    = '1;
   localparam logic [STEP_W-1:0]       STEP_LAST   = '1;
   localparam logic signed [DATA_W-1:0] HOP_RESET  = DATA_W'(65536);

   localparam logic [63:0] MASK32  = 64'hFFFF_FFFF;
   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FSQ,
      ST_MUL,
      ST_DIFF,
      ST_ABS,
      ST_SQR,
      ST_DEN,
      ST_CHECK,
      ST_DIVIDE,
      ST_ACCUM
   } state_type;

   typedef enum logic [0:0] {
      CSR_CHEMICAL_POTENTIAL,
      CSR_HOPPING_ENERGY
   } csr_index_type;

   typedef logic signed [COS_W-1:0] cos_rom_type [LATTICE_SIZE];

   function automatic logic signed [COS_W-1:0] cos_phase(logic [63:0] phase);
      logic [63:0] ph;
      logic [63:0] a;
      logic [63:0] x2;
      logic [63:0] v;
      logic        neg;
      logic        use_sin;
      ph      = phase & MASK32;
      neg     = 1'b0;
      use_sin = 1'b0;
      if (ph > 64'h8000_0000) ph = 64'h1_0000_0000 - ph;
      if (ph > 64'h4000_0000) begin
         ph  = 64'h8000_0000 - ph;
         neg = 1'b1;
      end
      if (ph > 64'h2000_0000) begin
         ph      = 64'h4000_0000 - ph;
         use_sin = 1'b1;
      end
      a  = (ph * PI_Q30) >> 31;
      x2 = (a * a) >> 30;
      if (use_sin) begin
         v = Q30_ONE - ((x2 * Q30_ONE) >> 30) / 72;
         v = Q30_ONE - ((x2 * v) >> 30) / 42;
         v = Q30_ONE - ((x2 * v) >> 30) / 20;
         v = Q30_ONE - ((x2 * v) >> 30) / 6;
         v = (a * v) >> 30;
      end else begin
         v = Q30_ONE - ((x2 * Q30_ONE) >> 30) / 90;
         v = Q30_ONE - ((x2 * v) >> 30) / 56;
         v = Q30_ONE - ((x2 * v) >> 30) / 30;
         v = Q30_ONE - ((x2 * v) >> 30) / 12;
         v = Q30_ONE - ((x2 * v) >> 30) / 2;
      end
      v = (v + 64'd8192) >> 14;
      if (neg) v = -v;
      return v[COS_W-1:0];
   endfunction

   function automatic cos_rom_type build_cos_rom();
      cos_rom_type rom;
      for (int p = 0; p < LATTICE_SIZE; p++) begin
         rom[p] = cos_phase(((64'(p) << 32) / LATTICE_SIZE) + 64'h8000_0000);
      end
      return rom;
   endfunction

   localparam cos_rom_type COS_ROM = build_cos_rom();

endpackage

// File: hw/rtl/lattice_green_function_sum.sv
// Lattice Green-function sum: grid mean of 1/(f^2 + (e - mu)^2) over an LxL grid.
// Uses lgfs_pkg (widths, FSM states, CSR codes, cosine table).
//
// Each request forms f^2 once in ST_FSQ; each of the N = L*L = 256 grid points then passes
// through ST_MUL, ST_DIFF, ST_ABS, ST_SQR, ST_DEN, ST_CHECK, the shared restoring divider
// (ST_DIVIDE) when its reciprocal is not saturated or zero, and ST_ACCUM. One frequency
// at a time: busy stays high until the result strobe, and start is taken again in the
// strobe cycle. The receiver cannot stall. Synchronous reset: FSM to idle, mu to 0, t to 1.0.
module lattice_green_function_sum
   import lgfs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_frequency,
   output logic                     rsp_valid,
   output logic [DATA_W-1:0]        rsp_mean_value,
   output logic                     rsp_saturated,
   input  logic                     csr_write_enable,
   input  logic                     csr_index,
   input  logic [DATA_W-1:0]        csr_write_data
);

   state_type state_ff, state_in;

   logic signed [DATA_W-1:0] mu_ff;
   logic signed [DATA_W-1:0] hop_ff;

   logic signed [DATA_W-1:0] freq_ff, freq_in;
   logic [DEN_W-1:0]         f_sq_ff, f_sq_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [AD_W-1:0]          ad_ff, ad_in;
   logic                     ad_big_ff, ad_big_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]         divisor_ff, divisor_in;
   logic [DATA_W-1:0]        quot_ff, quot_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic                     sat_ff, sat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_mean_ff, rsp_mean_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   logic [LAT_W-1:0]         px;
   logic [LAT_W-1:0]         py;
   logic signed [G_W-1:0]    cos_x;
   logic signed [G_W-1:0]    cos_y;
   logic signed [G_W-1:0]    g_value;
   logic [DATA_W-1:0]        freq_abs;
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [2*MUL_W-1:0] mul_prod;
   logic [RND_W-1:0]         mag_round;
   logic [RND_W-17:0]        ad_full;
   logic [DIV_W-1:0]         rem_shift;
   logic [DIV_W:0]           trial;
   logic                     term_sat;
   logic                     need_div;
   logic [SUM_W-1:0]         acc_sum;

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_value = rsp_mean_ff;
   assign rsp_saturated  = rsp_sat_ff;

   assign px      = idx_ff[IDX_W-1:LAT_W];
   assign py      = idx_ff[LAT_W-1:0];
   assign cos_x   = G_W'(COS_ROM[px]);
   assign cos_y   = (DIMENSIONS >= 2) ? G_W'(COS_ROM[py]) : '0;
   assign g_value = G_BASE - ((cos_x + cos_y) <<< 1);

   assign freq_abs  = freq_ff[DATA_W-1] ? DATA_W'(-freq_ff) : DATA_W'(freq_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_FSQ: begin
            mul_a = {1'b0, freq_abs};
            mul_b = {1'b0, freq_abs};
         end
         ST_MUL: begin
            mul_a = MUL_W'(hop_ff);
            mul_b = MUL_W'(g_value);
         end
         ST_SQR: begin
            mul_a = MUL_W'(ad_ff);
            mul_b = MUL_W'(ad_ff);
         end
         default: ;
      endcase
   end

   assign mul_prod  = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);
   assign mag_round = diff_ff[DIFF_W-1] ? ({1'b0, ~diff_ff} + ROUND_NEG)
                                        : ({1'b0, diff_ff} + ROUND_POS);
   assign ad_full   = mag_round[RND_W-1:16];

   assign rem_shift = {rem_ff, 1'b0};
   assign trial     = {1'b0, rem_shift} - {1'b0, divisor_ff};

   assign term_sat = !ad_big_ff && (den_ff <= SAT_LIMIT);
   assign need_div = !ad_big_ff && (den_ff > SAT_LIMIT) && (den_ff <= DIV_LIMIT);
   assign acc_sum  = sum_ff + SUM_W'(quot_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_FSQ;
         ST_FSQ:    state_in = ST_MUL;
         ST_MUL:    state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_ABS;
         ST_ABS:    state_in = ST_SQR;
         ST_SQR:    state_in = ST_DEN;
         ST_DEN:    state_in = ST_CHECK;
         ST_CHECK:  state_in = need_div ? ST_DIVIDE : ST_ACCUM;
         ST_DIVIDE: if (step_ff == STEP_LAST) state_in = ST_ACCUM;
         ST_ACCUM:  state_in = (idx_ff == IDX_LAST) ? ST_IDLE : ST_MUL;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      freq_in      = freq_ff;
      f_sq_in      = f_sq_ff;
      prod_in      = prod_ff;
      diff_in      = diff_ff;
      ad_in        = ad_ff;
      ad_big_in    = ad_big_ff;
      sq_in        = sq_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      sat_in       = sat_ff;
      rsp_valid_in = 1'b0;
      rsp_mean_in  = rsp_mean_ff;
      rsp_sat_in   = rsp_sat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               freq_in = req_frequency;
               idx_in  = '0;
               sum_in  = '0;
               sat_in  = 1'b0;
            end
         end
         ST_FSQ:  f_sq_in = mul_prod[DEN_W-1:0];
         ST_MUL:  prod_in = mul_prod[PROD_W-1:0];
         ST_DIFF: diff_in = DIFF_W'(prod_ff) - (DIFF_W'(mu_ff) <<< 16);
         ST_ABS: begin
            ad_in     = ad_full[AD_W-1:0];
            ad_big_in = (ad_full > AD_LIMIT);
         end
         ST_SQR:  sq_in = mul_prod[SQ_W-1:0];
         ST_DEN:  den_in = f_sq_ff + DEN_W'(sq_ff);
         ST_CHECK: begin
            rem_in     = REM_INIT;
            divisor_in = den_ff[DIV_W-1:0];
            step_in    = '0;
            if (term_sat) begin
               quot_in = QUO_MAX;
               sat_in  = 1'b1;
            end else begin
               quot_in = '0;
            end
         end
         ST_DIVIDE: begin
            quot_in = {quot_ff[DATA_W-2:0], ~trial[DIV_W]};
            rem_in  = trial[DIV_W] ? rem_shift[REM_W-1:0] : trial[REM_W-1:0];
            step_in = step_ff + 1'b1;
         end
         ST_ACCUM: begin
            sum_in = acc_sum;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = acc_sum[SUM_W-1:IDX_W];
               rsp_sat_in   = sat_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff  <= '0;
         hop_ff <= HOP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CHEMICAL_POTENTIAL: mu_ff  <= csr_write_data;
            CSR_HOPPING_ENERGY:     hop_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      freq_ff    <= freq_in;
      f_sq_ff    <= f_sq_in;
      prod_ff    <= prod_in;
      diff_ff    <= diff_in;
      ad_ff      <= ad_in;
      ad_big_ff  <= ad_big_in;
      sq_ff      <= sq_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
      step_ff    <= step_in;
      idx_ff     <= idx_in;
      sum_ff     <= sum_in;
      sat_ff     <= sat_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

endmodule
